// ----- hdl/block_average_overvoltage_trip_top_macros.svh -----
// assertion macros shared by the block average overvoltage trip rtl
`ifndef BLOCK_AVERAGE_OVERVOLTAGE_TRIP_TOP_MACROS_SVH
`define BLOCK_AVERAGE_OVERVOLTAGE_TRIP_TOP_MACROS_SVH

// condition that must hold on every clock edge out of reset
`define BAOT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequence that must hold in the same cycle as the cause
`define BAOT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence that must hold in the cycle after the cause
`define BAOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/baot_pkg.sv -----
// types and constants for the block average overvoltage trip
`default_nettype none

package baot_pkg;

    localparam int ADC_W     = 12;
    localparam int NUM_CH    = 4;
    localparam int AVG_W     = 15;
    localparam int LIMIT_W   = 12;
    localparam int COUNT_W   = 8;
    localparam int STATE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    // sets per block; the averaging shift needs a power of two
    localparam int BLOCK_LEN  = 8;
    localparam int BLOCK_LOG2 = $clog2(BLOCK_LEN);
    localparam int IDX_W      = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;
    localparam int SUM_W      = ADC_W + BLOCK_LOG2;
    // sum scaled to 15.3 before the shift by the block length
    localparam int FRAC_BITS  = 3;

    localparam logic [LIMIT_W-1:0] BUS_LIMIT_RESET  = LIMIT_W'(3000);
    localparam logic [COUNT_W-1:0] TRIP_COUNT_RESET = COUNT_W'(5);

    // channel order inside the sum array
    localparam int CH_BUS  = 0;
    localparam int CH_VOUT = 1;
    localparam int CH_CUR  = 2;
    localparam int CH_VIN  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_LIMIT  = 1'b0,
        CFG_TRIP_COUNT = 1'b1
    } baot_cfg_idx_t;

    typedef enum logic [2:0] {
        GUARD_NORMAL  = 3'b001,
        GUARD_PENDING = 3'b010,
        GUARD_TRIPPED = 3'b100
    } baot_guard_t;

    localparam logic [STATE_W-1:0] CODE_NORMAL  = 2'd0;
    localparam logic [STATE_W-1:0] CODE_PENDING = 2'd1;
    localparam logic [STATE_W-1:0] CODE_TRIPPED = 2'd2;

    typedef struct packed {
        logic [ADC_W-1:0] bus_sample;
        logic [ADC_W-1:0] vout_sample;
        logic [ADC_W-1:0] current_sample;
        logic [ADC_W-1:0] vin_sample;
        logic             fault_clear;
    } baot_in_t;

    typedef struct packed {
        logic [AVG_W-1:0]   bus_average;
        logic [AVG_W-1:0]   vout_average;
        logic [AVG_W-1:0]   current_average;
        logic [AVG_W-1:0]   vin_average;
        logic               fault_flag;
        logic [STATE_W-1:0] guard_state;
        logic [COUNT_W-1:0] over_count;
    } baot_out_t;

    function automatic logic [STATE_W-1:0] guard_code(input baot_guard_t mode);
        logic [STATE_W-1:0] code;
        unique case (mode)
            GUARD_PENDING: code = CODE_PENDING;
            GUARD_TRIPPED: code = CODE_TRIPPED;
            default:       code = CODE_NORMAL;
        endcase
        return code;
    endfunction

    // block sum to unsigned 12.3 average
    function automatic logic [AVG_W-1:0] block_average(input logic [SUM_W-1:0] sum);
        logic [SUM_W+FRAC_BITS-1:0] scaled;
        scaled = {sum, {FRAC_BITS{1'b0}}} >> BLOCK_LOG2;
        return scaled[AVG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/block_average_overvoltage_trip_top.sv -----
// block average overvoltage trip: top level with accumulators, guard and result register
// a block-ending request shows its result in the cycle after acceptance
// throughput: one request per cycle; one result per block of BLOCK_LEN requests
// only the block-ending request waits on a full, stalled result register
// reset (aresetn low, synchronous): sums, index, guard, count, fault, result valid and config to defaults
`default_nettype none
`include "block_average_overvoltage_trip_top_macros.svh"

module block_average_overvoltage_trip_top
    import baot_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample requests
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire baot_in_t              s_data,
    // block results
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output baot_out_t                  m_data,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_LEN - 1);

    // configuration registers
    logic [LIMIT_W-1:0] bus_limit_reg, bus_limit_next;
    logic [COUNT_W-1:0] trip_limit_reg, trip_limit_next;

    // block accumulation state
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_reg  [NUM_CH];
    logic [SUM_W-1:0]   sum_next [NUM_CH];
    logic [SUM_W-1:0]   sum_add  [NUM_CH];
    logic [ADC_W-1:0]   sample   [NUM_CH];

    // overvoltage guard
    baot_guard_t        guard_reg, guard_next, guard_step;
    logic [COUNT_W-1:0] count_reg, count_next, count_step, count_inc;
    logic               fault_reg, fault_next, fault_step;

    // result register
    logic               m_valid_reg, m_valid_next;
    baot_out_t          m_data_reg, m_data_next;

    logic               idx_last;
    logic               out_free;
    logic               s_accept;
    logic               cfg_accept;
    logic               block_end;
    logic               over;
    logic [SUM_W-1:0]   limit_scaled;

    // config port never stalls
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // a request that does not end a block has no result, so it never waits
    assign idx_last  = (idx_reg == LAST_IDX);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = out_free || !idx_last;
    assign s_accept  = s_valid && s_ready;
    assign block_end = s_accept && idx_last;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sample[CH_BUS]  = s_data.bus_sample;
    assign sample[CH_VOUT] = s_data.vout_sample;
    assign sample[CH_CUR]  = s_data.current_sample;
    assign sample[CH_VIN]  = s_data.vin_sample;

    // running sums, including the current request
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum_add[c] = sum_reg[c] + SUM_W'(sample[c]);
        end
    end

    // average above limit is the same as sum above limit times block length
    assign limit_scaled = SUM_W'(bus_limit_reg) * SUM_W'(BLOCK_LEN);
    assign over         = (sum_add[CH_BUS] > limit_scaled);
    assign count_inc    = count_reg + COUNT_W'(1);

    // one guard step, used only on a block end
    always_comb begin
        guard_step = guard_reg;
        count_step = count_reg;
        fault_step = fault_reg;
        unique case (guard_reg)
            GUARD_PENDING: begin
                if (over) begin
                    count_step = count_inc;
                    if (count_inc >= trip_limit_reg) begin
                        guard_step = GUARD_TRIPPED;
                        fault_step = 1'b1;
                    end
                end else begin
                    guard_step = GUARD_NORMAL;
                    count_step = '0;
                end
            end
            GUARD_TRIPPED: begin
                // count is kept until the next normal step
                if (s_data.fault_clear) begin
                    guard_step = GUARD_NORMAL;
                    fault_step = 1'b0;
                end
            end
            default: begin
                count_step = '0;
                guard_step = over ? GUARD_PENDING : GUARD_NORMAL;
            end
        endcase
    end

    always_comb begin
        bus_limit_next  = bus_limit_reg;
        trip_limit_next = trip_limit_reg;
        if (cfg_accept) begin
            unique case (baot_cfg_idx_t'(cfg_index))
                CFG_BUS_LIMIT:  bus_limit_next  = cfg_data[LIMIT_W-1:0];
                CFG_TRIP_COUNT: trip_limit_next = cfg_data[COUNT_W-1:0];
                default: begin
                    bus_limit_next  = bus_limit_reg;
                    trip_limit_next = trip_limit_reg;
                end
            endcase
        end
    end

    // accumulate, and on a block end clear sums, step the guard and load the result
    always_comb begin
        idx_next     = idx_reg;
        guard_next   = guard_reg;
        count_next   = count_reg;
        fault_next   = fault_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        for (int c = 0; c < NUM_CH; c++) begin
            sum_next[c] = sum_reg[c];
        end
        if (s_accept) begin
            idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
            for (int c = 0; c < NUM_CH; c++) begin
                sum_next[c] = idx_last ? '0 : sum_add[c];
            end
        end
        if (block_end) begin
            guard_next   = guard_step;
            count_next   = count_step;
            fault_next   = fault_step;
            m_valid_next = 1'b1;
            m_data_next.bus_average     = block_average(sum_add[CH_BUS]);
            m_data_next.vout_average    = block_average(sum_add[CH_VOUT]);
            m_data_next.current_average = block_average(sum_add[CH_CUR]);
            m_data_next.vin_average     = block_average(sum_add[CH_VIN]);
            m_data_next.fault_flag      = fault_step;
            m_data_next.guard_state     = guard_code(guard_step);
            m_data_next.over_count      = count_step;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_limit_reg  <= BUS_LIMIT_RESET;
            trip_limit_reg <= TRIP_COUNT_RESET;
            idx_reg        <= '0;
            guard_reg      <= GUARD_NORMAL;
            count_reg      <= '0;
            fault_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= '0;
            end
        end else begin
            bus_limit_reg  <= bus_limit_next;
            trip_limit_reg <= trip_limit_next;
            idx_reg        <= idx_next;
            guard_reg      <= guard_next;
            count_reg      <= count_next;
            fault_reg      <= fault_next;
            m_valid_reg    <= m_valid_next;
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // fault latch and tripped state always move together
    `BAOT_ASSERT_ALWAYS(a_fault_matches_guard, fault_reg == (guard_reg == GUARD_TRIPPED), "fault latch out of step with guard")

    // a shown result carries a fault flag that agrees with its state code
    `BAOT_ASSERT_SAME(a_result_flag_code, m_valid_reg, m_data_reg.fault_flag == (m_data_reg.guard_state == CODE_TRIPPED), "result fault flag disagrees with state")

    // a block end always produces a result
    `BAOT_ASSERT_NEXT(a_block_end_result, block_end, m_valid_reg, "block end without result")

    // a mid-block request never drops a stalled result
    `BAOT_ASSERT_NEXT(a_stall_kept, s_accept && !idx_last && m_valid_reg && !m_ready, m_valid_reg && $stable(m_data_reg), "stalled result lost")

endmodule

`default_nettype wire
